/* rtl/core/tlvs_pkg.sv */
// Shared types and constants of the thick line vector splitter.
package tlvs_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam logic [4:0] MAX_BRUSH_WIDTH = 5'd31;
	localparam logic [6:0] RUN_CAP = 7'd64;

	localparam logic [1:0] REG_BRUSH_WIDTH = 2'd0;
	localparam logic [1:0] REG_TEXTURED = 2'd1;
	localparam logic [1:0] REG_RASTER_OP = 2'd2;

	// One prepared segment handed from the front end to the vector generator.
	typedef struct packed {
		logic thin;
		logic poly;
		logic ymaj;
		logic pos;
		logic [15:0] x0;
		logic [15:0] y0;
		logic [15:0] x1;
		logic [15:0] y1;
		logic signed [7:0] err;
		logic [4:0] minax;
		logic [4:0] majax;
		logic [9:0] diag;
	} job_t;

endpackage

/* rtl/core/tlvs_front.sv */
// Front end: takes a segment, finds its length and half-width offsets, builds a job.
module tlvs_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [14:0] start_x,
	input  logic signed [14:0] start_y,
	input  logic signed [14:0] end_x,
	input  logic signed [14:0] end_y,
	input  logic poly_segment,
	input  logic [4:0] brush_width,
	output logic job_valid,
	input  logic job_ready,
	output tlvs_pkg::job_t job
);

	localparam logic [4:0] MAX_BRUSH_WIDTH_L = tlvs_pkg::MAX_BRUSH_WIDTH;

	typedef enum logic [6:0] {
		F_IDLE = 7'b0000001,
		F_SQA  = 7'b0000010,
		F_SQB  = 7'b0000100,
		F_ROOT = 7'b0001000,
		F_DIVA = 7'b0010000,
		F_DIVB = 7'b0100000,
		F_PUSH = 7'b1000000
	} fstate_t;

	fstate_t state_q;
	logic signed [15:0] sx_q, sy_q, ex_q, ey_q, dx_q, dy_q;
	logic poly_q, thin_q;
	logic [4:0] w_q;
	logic [31:0] rad_q;
	logic [15:0] root_q;
	logic [3:0] bit_q;
	logic [19:0] dvd_q;
	logic [15:0] rem_q;
	logic [4:0] cnt_q;
	logic [3:0] dyp_q, dxp_q;

	logic signed [15:0] dx_in, dy_in;
	logic [4:0] w_in;
	logic [14:0] adx, ady;
	logic [15:0] cand;
	logic [31:0] cand_sq;
	logic [16:0] div_r;
	logic div_ge;
	logic [16:0] div_diff;
	logic [15:0] rem_n;
	logic [19:0] dvd_n;
	logic ymaj, pos;
	logic signed [15:0] dxp_s, dyp_s;

	assign dx_in = 16'(end_x) - 16'(start_x);
	assign dy_in = 16'(end_y) - 16'(start_y);
	assign w_in = (brush_width > MAX_BRUSH_WIDTH_L) ? MAX_BRUSH_WIDTH_L : brush_width;

	assign adx = dx_q[15] ? 15'(-dx_q) : dx_q[14:0];
	assign ady = dy_q[15] ? 15'(-dy_q) : dy_q[14:0];

	assign cand = root_q | (16'd1 << bit_q);
	assign cand_sq = cand * cand;

	assign div_r = {rem_q, dvd_q[19]};
	assign div_ge = div_r >= {1'b0, root_q};
	assign div_diff = div_r - {1'b0, root_q};
	assign rem_n = div_ge ? div_diff[15:0] : div_r[15:0];
	assign dvd_n = {dvd_q[18:0], div_ge};

	assign in_ready = (state_q == F_IDLE);
	assign job_valid = (state_q == F_PUSH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						if (w_in <= 5'd1 || (dx_in == 16'sd0 && dy_in == 16'sd0)) begin
							state_q <= F_PUSH;
						end else begin
							state_q <= F_SQA;
						end
					end
				end
				F_SQA: state_q <= F_SQB;
				F_SQB: state_q <= F_ROOT;
				F_ROOT: begin
					if (bit_q == 4'd0) begin
						state_q <= F_DIVA;
					end
				end
				F_DIVA: begin
					if (cnt_q == 5'd0) begin
						state_q <= F_DIVB;
					end
				end
				F_DIVB: begin
					if (cnt_q == 5'd0) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (job_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				sx_q <= 16'(start_x);
				sy_q <= 16'(start_y);
				ex_q <= 16'(end_x);
				ey_q <= 16'(end_y);
				dx_q <= dx_in;
				dy_q <= dy_in;
				poly_q <= poly_segment;
				w_q <= w_in;
				thin_q <= (w_in <= 5'd1) || (dx_in == 16'sd0 && dy_in == 16'sd0);
			end
			F_SQA: rad_q <= 32'(adx * adx);
			F_SQB: begin
				rad_q <= rad_q + 32'(ady * ady);
				root_q <= 16'd0;
				bit_q <= 4'd15;
			end
			F_ROOT: begin
				if (cand_sq <= rad_q) begin
					root_q <= cand;
				end
				bit_q <= bit_q - 4'd1;
				dvd_q <= 20'(w_q * adx);
				rem_q <= 16'd0;
				cnt_q <= 5'd19;
			end
			F_DIVA: begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					dyp_q <= dvd_n[4:1];
					dvd_q <= 20'(w_q * ady);
					rem_q <= 16'd0;
					cnt_q <= 5'd19;
				end else begin
					dvd_q <= dvd_n;
					rem_q <= rem_n;
				end
			end
			F_DIVB: begin
				cnt_q <= cnt_q - 5'd1;
				dvd_q <= dvd_n;
				rem_q <= rem_n;
				if (cnt_q == 5'd0) begin
					dxp_q <= dvd_n[4:1];
				end
			end
			default: ;
		endcase
	end

	// Build the job: offsets move both endpoints across the line's major axis.
	assign pos = !((!dx_q[15] && dx_q != 16'sd0) ^ (!dy_q[15] && dy_q != 16'sd0));
	assign ymaj = dxp_q > dyp_q;
	assign dxp_s = {12'd0, dxp_q};
	assign dyp_s = {12'd0, dyp_q};

	always_comb begin
		job.thin = thin_q;
		job.poly = poly_q;
		job.ymaj = ymaj;
		job.pos = pos;
		job.diag = 10'(w_q * w_q);
		if (thin_q) begin
			job.x0 = sx_q;
			job.y0 = sy_q;
			job.x1 = ex_q;
			job.y1 = ey_q;
			job.err = 8'sd0;
			job.minax = 5'd0;
			job.majax = 5'd0;
		end else if (ymaj) begin
			job.x0 = sx_q - dxp_s;
			job.x1 = ex_q - dxp_s;
			job.y0 = pos ? sy_q + dyp_s : sy_q - dyp_s;
			job.y1 = pos ? ey_q + dyp_s : ey_q - dyp_s;
			job.err = $signed({3'd0, dyp_q, 1'b0}) - $signed({4'd0, dxp_q});
			job.minax = {dyp_q, 1'b0};
			job.majax = {dxp_q, 1'b0};
		end else begin
			job.y0 = sy_q - dyp_s;
			job.y1 = ey_q - dyp_s;
			job.x0 = pos ? sx_q + dxp_s : sx_q - dxp_s;
			job.x1 = pos ? ex_q + dxp_s : ex_q - dxp_s;
			job.err = $signed({3'd0, dxp_q, 1'b0}) - $signed({4'd0, dyp_q});
			job.minax = {dxp_q, 1'b0};
			job.majax = {dyp_q, 1'b0};
		end
	end

endmodule

/* rtl/core/tlvs_queue.sv */
// Short job queue between the front end and the vector generator.
module tlvs_queue #(
	parameter int DEPTH = tlvs_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  tlvs_pkg::job_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output tlvs_pkg::job_t pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	tlvs_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = count_q != FULL;
	assign pop_valid = count_q != '0;
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

/* rtl/core/tlvs_back.sv */
// Vector generator: steps across brush width; one vector per unstalled cycle.
module tlvs_back (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  tlvs_pkg::job_t job,
	input  logic textured_mode,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [15:0] vec_x0,
	output logic signed [15:0] vec_y0,
	output logic signed [15:0] vec_x1,
	output logic signed [15:0] vec_y1,
	output logic texture_continues,
	output logic poly_flag,
	output logic last_vector
);

	typedef enum logic [3:0] {
		B_IDLE   = 4'b0001,
		B_THIN   = 4'b0010,
		B_MAIN   = 4'b0100,
		B_SECOND = 4'b1000
	} bstate_t;

	bstate_t state_q;
	logic [15:0] x0_q, y0_q, x1_q, y1_q;
	logic signed [7:0] err_q;
	logic [6:0] mc_q, nc_q, cnt_q;
	logic [13:0] msq_q, nsq_q;
	logic signed [15:0] seg_q;
	logic ymaj_q, pos_q, poly_q;
	logic [4:0] minax_q, majax_q;
	logic [9:0] diag_q;
	logic out_valid_q;

	logic emit_ok, emit, cap, epos, brk, last;
	logic [6:0] cnt_n;
	logic [13:0] msq_n, nsq_n;
	logic signed [7:0] err_n;
	logic signed [15:0] seg_n;
	logic [15:0] abs_n, abs_o;
	logic [15:0] step;

	assign emit_ok = !out_valid_q || out_ready;
	assign emit = emit_ok && (state_q != B_IDLE);
	assign job_ready = (state_q == B_IDLE);
	assign out_valid = out_valid_q;
	assign cnt_n = cnt_q + 7'd1;
	assign cap = cnt_n == tlvs_pkg::RUN_CAP;
	assign step = pos_q ? 16'hFFFF : 16'd1;

	// A main step grows the major reach; a second vector grows the minor reach.
	always_comb begin
		msq_n = msq_q;
		nsq_n = nsq_q;
		err_n = err_q;
		if (state_q == B_SECOND) begin
			nsq_n = nsq_q + {6'd0, nc_q, 1'b0} + 14'd3;
			err_n = err_q - $signed({3'd0, majax_q});
		end else begin
			msq_n = msq_q + {6'd0, mc_q, 1'b0} + 14'd3;
			err_n = err_q + $signed({3'd0, minax_q});
		end
		seg_n = $signed({6'd0, diag_q}) - $signed({2'd0, msq_n + nsq_n});
		abs_n = seg_n[15] ? 16'(-seg_n) : seg_n;
		abs_o = seg_q[15] ? 16'(-seg_q) : seg_q;
		brk = abs_n > abs_o;
		epos = (state_q == B_MAIN) && !err_n[7] && err_n != 8'sd0;
		last = (state_q == B_THIN) || cap || (!epos && brk);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						state_q <= job.thin ? B_THIN : B_MAIN;
					end
				end
				B_THIN: begin
					if (emit) begin
						state_q <= B_IDLE;
					end
				end
				B_MAIN: begin
					if (emit) begin
						if (last) begin
							state_q <= B_IDLE;
						end else if (epos) begin
							state_q <= B_SECOND;
						end
					end
				end
				B_SECOND: begin
					if (emit) begin
						state_q <= last ? B_IDLE : B_MAIN;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE) begin
			x0_q <= job.x0;
			y0_q <= job.y0;
			x1_q <= job.x1;
			y1_q <= job.y1;
			err_q <= job.err;
			minax_q <= job.minax;
			majax_q <= job.majax;
			diag_q <= job.diag;
			ymaj_q <= job.ymaj;
			pos_q <= job.pos;
			poly_q <= job.poly;
			mc_q <= 7'd0;
			nc_q <= 7'd0;
			cnt_q <= 7'd0;
			msq_q <= 14'd1;
			nsq_q <= 14'd1;
			seg_q <= $signed({6'd0, job.diag}) - 16'sd2;
		end else if (emit) begin
			cnt_q <= cnt_n;
			err_q <= err_n;
			if (state_q == B_MAIN) begin
				mc_q <= mc_q + 7'd1;
				msq_q <= msq_n;
				if (!epos) begin
					seg_q <= seg_n;
				end
				if (ymaj_q) begin
					x0_q <= x0_q + 16'd1;
					x1_q <= x1_q + 16'd1;
				end else begin
					y0_q <= y0_q + 16'd1;
					y1_q <= y1_q + 16'd1;
				end
			end else if (state_q == B_SECOND) begin
				nc_q <= nc_q + 7'd1;
				nsq_q <= nsq_n;
				seg_q <= seg_n;
				if (ymaj_q) begin
					y0_q <= y0_q + step;
					y1_q <= y1_q + step;
				end else begin
					x0_q <= x0_q + step;
					x1_q <= x1_q + step;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			vec_x0 <= x0_q;
			vec_y0 <= y0_q;
			vec_x1 <= x1_q;
			vec_y1 <= y1_q;
			texture_continues <= (state_q != B_THIN) && textured_mode && (cnt_q != 7'd0);
			poly_flag <= poly_q;
			last_vector <= last;
		end
	end

endmodule

/* rtl/core/thick_line_vector_splitter.sv */
// Top level of the thick line vector splitter: configuration registers and wiring.
//
// channel   direction  words                         handshake
// in        input      start/end x,y, poly_segment   in_valid / in_ready
// out       output     one thin vector per word      out_valid / out_ready
// cfg       input      cfg_index, cfg_data           cfg_valid / cfg_ready
//
// The front end prepares one segment at a time: it squares both offsets, then
// takes a 16-step square root and two 20-step divisions on one shared divider.
// The generator sends one vector per cycle when not stalled, up to 64 per segment.
// A two-entry job queue lets the front end prepare the next segment meanwhile.
// Reset clears all control state; brush width resets to 1, other registers to 0.
// Output stalls hold the generator; a full queue holds the front end.
module thick_line_vector_splitter #(
	parameter int QUEUE_DEPTH = tlvs_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [14:0] start_x,
	input  logic signed [14:0] start_y,
	input  logic signed [14:0] end_x,
	input  logic signed [14:0] end_y,
	input  logic poly_segment,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [15:0] vec_x0,
	output logic signed [15:0] vec_y0,
	output logic signed [15:0] vec_x1,
	output logic signed [15:0] vec_y1,
	output logic texture_continues,
	output logic poly_flag,
	output logic [15:0] op_out,
	output logic last_vector,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	logic [4:0] brush_width_q;
	logic textured_q;
	logic [15:0] raster_op_q;

	logic fq_valid, fq_ready, qb_valid, qb_ready;
	tlvs_pkg::job_t fq_job, qb_job;

	assign cfg_ready = 1'b1;
	assign op_out = raster_op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brush_width_q <= 5'd1;
			textured_q <= 1'b0;
			raster_op_q <= 16'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tlvs_pkg::REG_BRUSH_WIDTH: brush_width_q <= cfg_data[4:0];
				tlvs_pkg::REG_TEXTURED:    textured_q <= cfg_data[0];
				tlvs_pkg::REG_RASTER_OP:   raster_op_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tlvs_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.poly_segment(poly_segment),
		.brush_width(brush_width_q),
		.job_valid(fq_valid),
		.job_ready(fq_ready),
		.job(fq_job)
	);

	tlvs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_data(fq_job),
		.pop_valid(qb_valid),
		.pop_ready(qb_ready),
		.pop_data(qb_job)
	);

	tlvs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(qb_valid),
		.job_ready(qb_ready),
		.job(qb_job),
		.textured_mode(textured_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.vec_x0(vec_x0),
		.vec_y0(vec_y0),
		.vec_x1(vec_x1),
		.vec_y1(vec_y1),
		.texture_continues(texture_continues),
		.poly_flag(poly_flag),
		.last_vector(last_vector)
	);

endmodule
